// ===== rtl/core/egs_pkg.sv =====
// ----------------------------------------------------------------------------
// egs_pkg
// Shared widths, constants and the divider command type of the glide smoother.
// ----------------------------------------------------------------------------
package egs_pkg;

   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int RATE_WIDTH       = 19;
   localparam int MS_WIDTH         = 24;

   localparam int DVD_WIDTH = 54;
   localparam int DVS_WIDTH = 42;
   localparam int CNT_WIDTH = 6;

   localparam int MUL_A_WIDTH = 33;
   localparam int MUL_B_WIDTH = 32;
   localparam int MUL_P_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;

   localparam logic [RATE_WIDTH-1:0] RATE_RESET = 19'd48000;

   // log2(1000) in Q.32 times 256000
   localparam logic [DVD_WIDTH-1:0] EXP_NUM   = 54'd10957495700992000;
   localparam logic [31:0]          LN2_Q32   = 32'd2977044472;
   localparam logic [3:0]           EXP_TERMS = 4'd13;

   localparam logic [CNT_WIDTH-1:0] ITERS_EXP  = 6'd54;
   localparam logic [CNT_WIDTH-1:0] ITERS_TERM = 6'd33;

   typedef struct packed {
      logic                 start;
      logic [CNT_WIDTH-1:0] iters;
   } div_cmd_type;

endpackage

// ===== rtl/core/egs_divider.sv =====
// ----------------------------------------------------------------------------
// egs_divider
// Restoring divider, one quotient bit per cycle, from the dividend MSB down.
// ----------------------------------------------------------------------------
module egs_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  egs_pkg::div_cmd_type           cmd,
   input  logic [egs_pkg::DVD_WIDTH-1:0]  dividend,
   input  logic [egs_pkg::DVS_WIDTH-1:0]  divisor,
   output logic                           done,
   output logic [egs_pkg::DVD_WIDTH-1:0]  quotient
);
   import egs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DVS_WIDTH:0]   rem_ff, rem_in;
   logic [DVS_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DVD_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DVD_WIDTH-1:0] quo_ff, quo_in;
   logic [DVS_WIDTH:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff[DVS_WIDTH-1:0], dvd_ff[DVD_WIDTH-1]};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.iters;
         rem_in  = '0;
         dvs_in  = divisor;
         dvd_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DVD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DVD_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/egs_mult.sv =====
// ----------------------------------------------------------------------------
// egs_mult
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module egs_mult (
   input  logic                             clock,
   input  logic [egs_pkg::MUL_A_WIDTH-1:0]  op_a,
   input  logic [egs_pkg::MUL_B_WIDTH-1:0]  op_b,
   output logic [egs_pkg::MUL_P_WIDTH-1:0]  product
);
   import egs_pkg::*;

   logic [MUL_P_WIDTH-1:0] prod_ff, prod_in;

   assign prod_in = {{MUL_B_WIDTH{1'b0}}, op_a} * {{MUL_A_WIDTH{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// ===== rtl/core/exponential_glide_smoother.sv =====
// ----------------------------------------------------------------------------
// exponential_glide_smoother
// One-pole smoother with per-sample glide time, coefficient 0.001^(1/(ms*kHz)).
// ----------------------------------------------------------------------------
// A clear zeroes the stored output and gives no result; a bypass result is registered
// and shows the cycle after acceptance. A glide request runs the serial divider for the
// exponent and then for each of the 13 series terms before its result is shown.
// A zero rate skips straight to the product; a very short glide skips the series.
// One request at a time; a new request is taken once the result slot is free.
// Synchronous reset: rate 48000 Hz, stored output zero, no result pending.
module exponential_glide_smoother #(
   parameter int SAMPLE_WIDTH = egs_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_sample_in,
   input  logic signed [egs_pkg::MS_WIDTH-1:0] req_glide_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_sample_out,
   input  logic                             csr_wr_en,
   input  logic [egs_pkg::RATE_WIDTH-1:0]   csr_wr_data
);
   import egs_pkg::*;

   localparam int MW = (SAMPLE_WIDTH + 1 > 33) ? SAMPLE_WIDTH + 1 : 33;
   localparam int YW = MW + 2;

   localparam logic signed [YW-1:0] SAT_HI =
      ({{(YW-1){1'b0}}, 1'b1} << (SAMPLE_WIDTH - 1)) - 1'b1;
   localparam logic signed [YW-1:0] SAT_LO = -SAT_HI - 1'b1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEN  = 4'd1;
   localparam logic [3:0] S_DIVS = 4'd2;
   localparam logic [3:0] S_DIVW = 4'd3;
   localparam logic [3:0] S_F    = 4'd4;
   localparam logic [3:0] S_TLD  = 4'd5;
   localparam logic [3:0] S_TM   = 4'd6;
   localparam logic [3:0] S_TDS  = 4'd7;
   localparam logic [3:0] S_TDW  = 4'd8;
   localparam logic [3:0] S_AC   = 4'd9;
   localparam logic [3:0] S_PLO  = 4'd10;
   localparam logic [3:0] S_PLOW = 4'd11;
   localparam logic [3:0] S_PHIW = 4'd12;

   logic [3:0]               state_ff, state_in;
   logic [RATE_WIDTH-1:0]    rate_ff, rate_in;
   logic [SAMPLE_WIDTH-1:0]  last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]  out_ff, out_in;
   logic [SAMPLE_WIDTH-1:0]  x_ff, x_in;
   logic [MS_WIDTH-2:0]      ms_ff, ms_in;
   logic [31:0]              f_ff, f_in;
   logic [4:0]               n_ff, n_in;
   logic [31:0]              t_ff, t_in;
   logic [32:0]              term_ff, term_in;
   logic signed [34:0]       sum_ff, sum_in;
   logic [3:0]               k_ff, k_in;
   logic [31:0]              a_ff, a_in;
   logic [32:0]              plo_ff, plo_in;

   logic [MUL_A_WIDTH-1:0]   mul_a;
   logic [MUL_B_WIDTH-1:0]   mul_b;
   logic [MUL_P_WIDTH-1:0]   prod;
   div_cmd_type              div_cmd;
   logic [DVD_WIDTH-1:0]     div_dvd;
   logic [DVS_WIDTH-1:0]     div_dvs;
   logic                     div_done;
   logic [DVD_WIDTH-1:0]     div_quo;

   logic signed [MW:0]       diff;
   logic                     neg;
   logic [MW-1:0]            mag;
   logic [MUL_P_WIDTH-1:0]   rnd;
   logic [MW:0]              p_sum;
   logic signed [YW-1:0]     y_raw;
   logic [SAMPLE_WIDTH-1:0]  y_sat;
   logic [33:0]              sum_pos;
   logic [33:0]              sum_shr;
   logic                     accept;

   egs_mult u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   egs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign diff = $signed({last_ff[SAMPLE_WIDTH-1], last_ff}) -
                 $signed({x_ff[SAMPLE_WIDTH-1], x_ff});
   assign neg  = diff[MW];
   assign mag  = neg ? MW'(-diff) : MW'(diff);

   assign rnd   = prod + 65'h80000000;
   assign p_sum = (MW + 1)'(prod[MW-1:0]) + (MW + 1)'(plo_ff);

   always_comb begin
      logic signed [YW-1:0] x_ext;
      x_ext = YW'($signed(x_ff));
      if (neg) begin
         y_raw = x_ext - $signed({1'b0, p_sum});
      end else begin
         y_raw = x_ext + $signed({1'b0, p_sum});
      end
      priority if (y_raw > SAT_HI) begin
         y_sat = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (y_raw < SAT_LO) begin
         y_sat = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         y_sat = y_raw[SAMPLE_WIDTH-1:0];
      end
   end

   assign sum_pos = sum_ff[34] ? 34'd0 : sum_ff[33:0];
   assign sum_shr = sum_pos >> n_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_DEN: begin
            mul_a = MUL_A_WIDTH'(ms_ff);
            mul_b = MUL_B_WIDTH'(rate_ff);
         end
         S_F: begin
            mul_a = {1'b0, f_ff};
            mul_b = LN2_Q32;
         end
         S_TM: begin
            mul_a = term_ff;
            mul_b = t_ff;
         end
         S_PLO: begin
            mul_a = {1'b0, mag[31:0]};
            mul_b = a_ff;
         end
         S_PLOW, S_PHIW: begin
            mul_a = MUL_A_WIDTH'(mag[MW-1:32]);
            mul_b = a_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rate_in      = csr_wr_en ? csr_wr_data : rate_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_in       = out_ff;
      x_in         = x_ff;
      ms_in        = ms_ff;
      f_in         = f_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      plo_in       = plo_ff;
      div_cmd      = '{start: 1'b0, iters: ITERS_EXP};
      div_dvd      = EXP_NUM;
      div_dvs      = prod[DVS_WIDTH-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in  = req_sample_in;
               ms_in = req_glide_ms[MS_WIDTH-2:0];
               priority if (req_func) begin
                  last_in = '0;
               end else if (req_glide_ms[MS_WIDTH-1] || req_glide_ms == '0) begin
                  out_in       = req_sample_in;
                  rsp_valid_in = 1'b1;
               end else if (rate_ff == '0) begin
                  a_in     = '0;
                  state_in = S_PLO;
               end else begin
                  state_in = S_DEN;
               end
            end
         end
         S_DEN: begin
            state_in = S_DIVS;
         end
         S_DIVS: begin
            div_cmd  = '{start: 1'b1, iters: ITERS_EXP};
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               f_in = div_quo[31:0];
               n_in = div_quo[36:32];
               if (|div_quo[DVD_WIDTH-1:37]) begin
                  a_in     = '0;
                  state_in = S_PLO;
               end else begin
                  state_in = S_F;
               end
            end
         end
         S_F: begin
            state_in = S_TLD;
         end
         S_TLD: begin
            t_in     = prod[63:32];
            term_in  = 33'h1_0000_0000;
            sum_in   = 35'sh1_0000_0000;
            k_in     = 4'd1;
            state_in = S_TM;
         end
         S_TM: begin
            state_in = S_TDS;
         end
         S_TDS: begin
            div_cmd  = '{start: 1'b1, iters: ITERS_TERM};
            div_dvd  = {prod[64:32], {(DVD_WIDTH-33){1'b0}}};
            div_dvs  = DVS_WIDTH'(k_ff);
            state_in = S_TDW;
         end
         S_TDW: begin
            if (div_done) begin
               term_in = div_quo[32:0];
               if (k_ff[0]) begin
                  sum_in = sum_ff - $signed({2'b00, div_quo[32:0]});
               end else begin
                  sum_in = sum_ff + $signed({2'b00, div_quo[32:0]});
               end
               if (k_ff == EXP_TERMS) begin
                  state_in = S_AC;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_TM;
               end
            end
         end
         S_AC: begin
            a_in     = (|sum_shr[33:32]) ? 32'hFFFF_FFFF : sum_shr[31:0];
            state_in = S_PLO;
         end
         S_PLO: begin
            state_in = S_PLOW;
         end
         S_PLOW: begin
            // round the low partial product to nearest, halves up
            plo_in   = rnd[64:32];
            state_in = S_PHIW;
         end
         S_PHIW: begin
            // hold until the result slot drains
            if (!rsp_valid_ff || rsp_ready) begin
               last_in      = y_sat;
               out_in       = y_sat;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hi partial product must stay in the product register while waiting
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= RATE_RESET;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff  <= out_in;
      x_ff    <= x_in;
      ms_ff   <= ms_in;
      f_ff    <= f_in;
      n_ff    <= n_in;
      t_ff    <= t_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      k_ff    <= k_in;
      a_ff    <= a_in;
      plo_ff  <= plo_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

endmodule
